[rtl/core/bepm_pkg.sv]
package bepm_pkg;

   // Frame size limits
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   // Register and index widths
   localparam int CFG_W     = 11;
   localparam int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int CSR_IDX_W = 1;

   // Reset value of both size registers
   localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(8);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic {
      CMD_PIXEL = 1'b0,
      CMD_DRAIN = 1'b1
   } cmd_type;

   // One line-store word: bit 1 = latest row written at this column, bit 0 = row before
   typedef logic [1:0] word_type;

   // Item travelling from the accept stage to the evaluate stage
   typedef struct packed {
      logic             is_pixel;   // below neighbor present and word written back
      logic             px;
      logic [COL_W-1:0] col;
      logic             emit;       // a result is produced
      logic             up_ok;      // upper neighbor lies inside the frame
      logic             row_end;    // last column of the row
      logic             frame_end;  // last result of the frame
   } item_type;

   // Width register to last column index: 0 acts as 1, large values clamp
   function automatic logic [COL_W-1:0] width_last(input logic [CFG_W-1:0] v);
      logic [COL_W-1:0] r;
      if (v == '0)
         r = '0;
      else if (int'(v) > MAX_WIDTH)
         r = COL_W'(MAX_WIDTH - 1);
      else
         r = COL_W'(v - CFG_W'(1));
      return r;
   endfunction

   // Height register to last row index, same clamping
   function automatic logic [ROW_W-1:0] height_last(input logic [CFG_W-1:0] v);
      logic [ROW_W-1:0] r;
      if (v == '0)
         r = '0;
      else if (int'(v) > MAX_HEIGHT)
         r = ROW_W'(MAX_HEIGHT - 1);
      else
         r = ROW_W'(v - CFG_W'(1));
      return r;
   endfunction

endpackage

[rtl/core/binary_edge_pixel_marker.sv]
// Binary boundary marker, 4-neighbor. Pixels enter row by row (req_cmd = 0); each
// result marks a foreground pixel that touches in-frame background above, below,
// left or right, and is given out for row r when the pixel of row r+1 at the same
// column arrives, so row 0 pixels emit nothing. After the last row, issue one drain
// (req_cmd = 1) per column to flush it; drains with nothing pending, and pixels sent
// while drains are pending, are dropped. Writing frame_width or frame_height restarts
// the frame; write them only while the block is idle. One item is taken every clock
// while rsp_ready stays high: the line store is a single-port-read, single-port-write
// memory of two bits per column, read one column ahead, with one evaluate stage and
// a result register behind it.
module binary_edge_pixel_marker (
   input  logic                                  clock,
   input  logic                                  reset,
   // pixel / drain input
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_cmd,
   input  logic                                  req_pixel,
   // results
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_edge_res,
   output logic                                  rsp_row_last,
   output logic                                  rsp_frame_last,
   // register writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bepm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [bepm_pkg::CFG_W-1:0]            csr_wdata
);
   import bepm_pkg::*;

   // Size registers, held as last index
   logic [COL_W-1:0] wlast_ff, wlast_in;
   logic [ROW_W-1:0] hlast_ff, hlast_in;

   // Frame position
   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic             drain_ff, drain_in;

   // Evaluate stage
   logic             s1_valid_ff, s1_valid_in;
   item_type         s1_ff, s1_in;

   // Column window: left bit of current row, word at current column, word at column 0
   logic             lft_ff, lft_in;
   word_type         ctr_ff, ctr_in;
   word_type         col0_ff, col0_in;

   // Line store
   word_type         mem [MAX_WIDTH];
   word_type         rd_ff;
   logic             rd_en;
   logic [COL_W-1:0] rd_addr;
   logic             we;
   logic [COL_W-1:0] wr_addr;
   word_type         wr_data;

   // Result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             edge_ff, edge_in;
   logic             rlast_ff, rlast_in;
   logic             flast_ff, flast_in;

   logic             req_fire, csr_fire, item_take, is_drain, s1_adv, edge_val;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   // Evaluate stage moves on when it emits no result or its result has a free slot
   assign s1_adv    = s1_valid_ff && (!s1_ff.emit || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_fire  = req_valid && req_ready;
   assign is_drain  = (cmd_type'(req_cmd) == CMD_DRAIN);
   assign item_take = req_fire && (is_drain ? drain_ff : !drain_ff);

   // Accept stage: decode item, advance counters, read one column ahead, take CSR writes
   always_comb begin
      wlast_in   = wlast_ff;
      hlast_in   = hlast_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      drain_in   = drain_ff;
      s1_in      = s1_ff;
      rd_en      = item_take;
      rd_addr    = (is_drain ? out_col_ff : in_col_ff) + COL_W'(1);

      if (is_drain) begin
         s1_in.is_pixel  = 1'b0;
         s1_in.px        = 1'b0;
         s1_in.col       = out_col_ff;
         s1_in.emit      = 1'b1;
         s1_in.up_ok     = (hlast_ff != '0);
         s1_in.row_end   = (out_col_ff == wlast_ff);
         s1_in.frame_end = (out_col_ff == wlast_ff);
      end else begin
         s1_in.is_pixel  = 1'b1;
         s1_in.px        = req_pixel;
         s1_in.col       = in_col_ff;
         s1_in.emit      = (in_row_ff != '0);
         s1_in.up_ok     = (in_row_ff != '0) && (in_row_ff != ROW_W'(1));
         s1_in.row_end   = (in_col_ff == wlast_ff);
         s1_in.frame_end = 1'b0;
      end

      if (csr_fire) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  wlast_in = width_last(csr_wdata);
            CSR_FRAME_HEIGHT: hlast_in = height_last(csr_wdata);
            default: ;
         endcase
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         drain_in   = 1'b0;
      end else if (item_take) begin
         if (is_drain) begin
            if (out_col_ff == wlast_ff) begin
               out_col_in = '0;
               drain_in   = 1'b0;
            end else begin
               out_col_in = out_col_ff + COL_W'(1);
            end
         end else if (in_col_ff == wlast_ff) begin
            in_col_in = '0;
            if (in_row_ff == hlast_ff) begin
               in_row_in  = '0;
               drain_in   = 1'b1;
               out_col_in = '0;
            end else begin
               in_row_in = in_row_ff + ROW_W'(1);
            end
         end else begin
            in_col_in = in_col_ff + COL_W'(1);
         end
      end

      if (item_take)
         s1_valid_in = 1'b1;
      else if (s1_adv)
         s1_valid_in = 1'b0;
      else
         s1_valid_in = s1_valid_ff;
   end

   // Evaluate stage: edge decision, write-back, window shift, result load
   always_comb begin
      edge_val = ctr_ff[1] && (
                    (s1_ff.up_ok && !ctr_ff[0]) ||
                    (s1_ff.is_pixel && !s1_ff.px) ||
                    ((s1_ff.col != '0) && !lft_ff) ||
                    (!s1_ff.row_end && !rd_ff[1]));

      we      = s1_adv && s1_ff.is_pixel;
      wr_addr = s1_ff.col;
      wr_data = {s1_ff.px, ctr_ff[1]};

      lft_in  = lft_ff;
      ctr_in  = ctr_ff;
      col0_in = col0_ff;
      if (we && (s1_ff.col == '0))
         col0_in = wr_data;
      if (s1_adv) begin
         lft_in = ctr_ff[1];
         ctr_in = s1_ff.row_end ? col0_in : rd_ff;
      end

      edge_in  = edge_ff;
      rlast_in = rlast_ff;
      flast_in = flast_ff;
      if (s1_adv && s1_ff.emit) begin
         rsp_valid_in = 1'b1;
         edge_in      = edge_val;
         rlast_in     = s1_ff.row_end;
         flast_in     = s1_ff.frame_end;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Line store, with the same-cycle write forwarded to the read
   always_ff @(posedge clock) begin
      if (we)
         mem[wr_addr] <= wr_data;
      if (rd_en)
         rd_ff <= (we && (wr_addr == rd_addr)) ? wr_data : mem[rd_addr];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wlast_ff     <= width_last(SIZE_RESET);
         hlast_ff     <= height_last(SIZE_RESET);
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_col_ff   <= '0;
         drain_ff     <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wlast_ff     <= wlast_in;
         hlast_ff     <= hlast_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         out_col_ff   <= out_col_in;
         drain_ff     <= drain_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (item_take)
         s1_ff <= s1_in;
      lft_ff   <= lft_in;
      ctr_ff   <= ctr_in;
      col0_ff  <= col0_in;
      edge_ff  <= edge_in;
      rlast_ff <= rlast_in;
      flast_ff <= flast_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_edge_res   = edge_ff;
   assign rsp_row_last   = rlast_ff;
   assign rsp_frame_last = flast_ff;

endmodule
